### design/stq_pkg.sv
package stq_pkg;

    // Queue size and the most entries that may expire on one tick.
    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;

    // Derived widths: slot index, entry count (0..depth), result count.
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int RES_W = $clog2(MAX_RESULTS + 1);

    // Configuration address map: one 32-bit register at byte address 0.
    localparam int ADDR_W = 3;
    localparam logic [ADDR_W-3:0] REG_TPS = '0;
    localparam logic [6:0] TPS_RESET = 7'd50;

    // Command codes.
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_EXPIRED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] handler_id;
        logic [15:0] delay_seconds;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] expired_id;
        logic        last;
    } t_out_item;

    // One queue slot: absolute deadline in seconds and its handler.
    typedef struct packed {
        logic [31:0] deadline;
        logic [15:0] handler;
    } t_entry;

endpackage

### design/sorted_timeout_queue.sv
// Channel   | Direction | Signals                               | Payload
// ----------+-----------+---------------------------------------+------------------
// in        | input     | i_in_valid, o_in_ready                | i_in_data (t_in_item)
// out       | output    | o_out_valid, i_out_ready              | o_out_data (t_out_item)
// config    | input     | psel, penable, pwrite, paddr, pwdata, | ticks_per_second
//           |           | prdata, pready                        | at address 0
//
// Insert and remove walk the queue once through the head slot.
// A tick without a second boundary, a full insert or an unused command goes straight
// to the response; at a boundary a tick pops each due entry in turn, up to MAX_RESULTS,
// all judged by the one shared deadline comparator.
// The block takes a new beat only when its sequencer is idle; a result waiting in the
// output register holds the response and expiry steps until that beat is taken.
// Reset is synchronous and active low; it empties the queue and loads the rate of 50.
module sorted_timeout_queue import stq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;
    localparam logic [2:0] S_REM  = 3'd2;
    localparam logic [2:0] S_EXP  = 3'd3;
    localparam logic [2:0] S_RESP = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [6:0]       r_tps;
    logic [6:0]       r_ticks, n_ticks;
    logic [31:0]      r_sec, n_sec;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_left, n_left;
    logic [RES_W-1:0] r_emit, n_emit;
    logic [31:0]      r_key, n_key;
    logic [15:0]      r_id, n_id;
    t_entry           r_car, n_car;
    logic             r_placed, n_placed;
    logic             r_pend_v, n_pend_v;
    logic [15:0]      r_pend_id, n_pend_id;
    logic [1:0]       r_st, n_st;
    logic             r_ov, n_ov;
    t_out_item        r_out, n_out;
    t_entry           r_q [QUEUE_DEPTH];
    t_entry           n_q [QUEUE_DEPTH];

    logic             in_acc;
    logic             cfg_wr;
    logic [31:0]      cmp_b;
    logic             cmp_lt;
    logic             cmp_eq;
    logic             q_pop;
    logic             q_push;
    t_entry           q_push_data;
    logic [CNT_W-1:0] wr_pos;
    logic [IDX_W-1:0] wr_idx;
    logic             due;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    // Configuration port: zero wait states, one rate register.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[ADDR_W-1:2] == REG_TPS) ? 32'(r_tps) : '0;

    // The shared comparator: head deadline against the insert key or the clock.
    assign cmp_b  = (r_state == S_INS) ? r_key : r_sec;
    assign cmp_lt = r_q[0].deadline < cmp_b;
    assign cmp_eq = r_q[0].deadline == cmp_b;
    assign due    = (r_count != '0) && (cmp_lt || cmp_eq) && (r_emit != RES_W'(MAX_RESULTS));

    // Sequencer: a walk step pops the head and may append one entry at the tail; the last insert step only appends.
    always_comb begin
        n_state     = r_state;
        n_ticks     = r_ticks;
        n_sec       = r_sec;
        n_count     = r_count;
        n_left      = r_left;
        n_emit      = r_emit;
        n_key       = r_key;
        n_id        = r_id;
        n_car       = r_car;
        n_placed    = r_placed;
        n_pend_v    = r_pend_v;
        n_pend_id   = r_pend_id;
        n_st        = r_st;
        n_ov        = r_ov && !i_out_ready;
        n_out       = r_out;
        q_pop       = 1'b0;
        q_push      = 1'b0;
        q_push_data = r_q[0];

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_data.cmd)
                        CMD_INSERT: begin
                            if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                                n_st    = ST_FULL;
                                n_state = S_RESP;
                            end else begin
                                n_key    = r_sec + 32'(i_in_data.delay_seconds);
                                n_car    = '{deadline: r_sec + 32'(i_in_data.delay_seconds),
                                             handler: i_in_data.handler_id};
                                n_placed = 1'b0;
                                n_left   = r_count;
                                n_state  = S_INS;
                            end
                        end
                        CMD_REMOVE: begin
                            n_id    = i_in_data.handler_id;
                            n_left  = r_count;
                            n_state = S_REM;
                        end
                        CMD_TICK: begin
                            if (r_ticks <= 7'd1) begin
                                n_ticks  = (r_tps == '0) ? 7'd1 : r_tps;
                                n_sec    = r_sec + 32'd1;
                                n_emit   = '0;
                                n_pend_v = 1'b0;
                                n_state  = S_EXP;
                            end else begin
                                n_ticks = r_ticks - 7'd1;
                                n_st    = ST_DONE;
                                n_state = S_RESP;
                            end
                        end
                        default: begin
                            n_st    = ST_DONE;
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_INS: begin
                // Insertion by carry: once the new entry is placed, each head is
                // swapped through the carry so the tail stays one slot behind.
                if (r_left != '0) begin
                    q_pop  = 1'b1;
                    q_push = 1'b1;
                    n_left = r_left - CNT_W'(1);
                    if (r_placed || !cmp_lt) begin
                        q_push_data = r_car;
                        n_car       = r_q[0];
                        n_placed    = 1'b1;
                    end
                end else begin
                    q_push      = 1'b1;
                    q_push_data = r_car;
                    n_count     = r_count + CNT_W'(1);
                    n_st        = ST_DONE;
                    n_state     = S_RESP;
                end
            end
            S_REM: begin
                // Entries with another id go back in at the tail, in order.
                if (r_left != '0) begin
                    q_pop  = 1'b1;
                    q_push = (r_q[0].handler != r_id);
                    n_left = r_left - CNT_W'(1);
                    if (r_q[0].handler == r_id) begin
                        n_count = r_count - CNT_W'(1);
                    end
                end else begin
                    n_st    = ST_DONE;
                    n_state = S_RESP;
                end
            end
            S_EXP: begin
                // One expired entry is held back so the final beat can carry last.
                if (!r_ov) begin
                    if (due) begin
                        q_pop     = 1'b1;
                        n_count   = r_count - CNT_W'(1);
                        n_emit    = r_emit + RES_W'(1);
                        n_pend_id = r_q[0].handler;
                        n_pend_v  = 1'b1;
                        if (r_pend_v) begin
                            n_ov  = 1'b1;
                            n_out = '{status: ST_EXPIRED, expired_id: r_pend_id, last: 1'b0};
                        end
                    end else begin
                        n_ov     = 1'b1;
                        n_pend_v = 1'b0;
                        n_state  = S_IDLE;
                        if (r_pend_v) begin
                            n_out = '{status: ST_EXPIRED, expired_id: r_pend_id, last: 1'b1};
                        end else begin
                            n_out = '{status: ST_DONE, expired_id: 16'd0, last: 1'b1};
                        end
                    end
                end
            end
            S_RESP: begin
                if (!r_ov) begin
                    n_ov    = 1'b1;
                    n_out   = '{status: r_st, expired_id: 16'd0, last: 1'b1};
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Tail position: after a pop the last live slot, otherwise the first free one.
    assign wr_pos = q_pop ? (r_count - CNT_W'(1)) : r_count;
    assign wr_idx = wr_pos[IDX_W-1:0];

    // Queue slots: shift toward the head, then write the appended entry.
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n_q[i] = r_q[i];
        end
        if (q_pop) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                n_q[i] = r_q[i + 1];
            end
        end
        if (q_push) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (wr_idx == IDX_W'(i)) begin
                    n_q[i] = q_push_data;
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tps    <= TPS_RESET;
            r_ticks  <= TPS_RESET;
            r_sec    <= '0;
            r_count  <= '0;
            r_left   <= '0;
            r_emit   <= '0;
            r_placed <= 1'b0;
            r_pend_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ticks  <= n_ticks;
            r_sec    <= n_sec;
            r_count  <= n_count;
            r_left   <= n_left;
            r_emit   <= n_emit;
            r_placed <= n_placed;
            r_pend_v <= n_pend_v;
            r_ov     <= n_ov;
            if (cfg_wr && (paddr[ADDR_W-1:2] == REG_TPS)) begin
                r_tps <= pwdata[6:0];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_id      <= n_id;
        r_car     <= n_car;
        r_pend_id <= n_pend_id;
        r_st      <= n_st;
        r_out     <= n_out;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

endmodule
